// ===== rtl/mia_pkg.sv =====
package mia_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int OPCODE_WIDTH   = 4;
    localparam int REG_WIDTH      = 5;
    localparam int SHAMT_WIDTH    = 5;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_AND   = 4'd2,
        OP_OR    = 4'd3,
        OP_XOR   = 4'd4,
        OP_NOR   = 4'd5,
        OP_SLL   = 4'd6,
        OP_SRL   = 4'd7,
        OP_SRA   = 4'd8,
        OP_SLT   = 4'd9,
        OP_SLTU  = 4'd10,
        OP_MULT  = 4'd11,
        OP_MULTU = 4'd12,
        OP_DIV   = 4'd13,
        OP_DIVU  = 4'd14,
        OP_NONE  = 4'd15
    } opcode_t;

    // Per-item control that travels down the pipeline beside the data.
    typedef struct packed {
        logic                 is_mul;
        logic                 is_div;
        logic                 gpr_write;
        logic [REG_WIDTH-1:0] write_reg;
    } ctl_t;

endpackage

// ===== rtl/mips_integer_alu.sv =====
// MIPS32 integer execute unit. Each transaction on the s_axis side carries an
// opcode, two operands and a destination register; exactly one result
// transaction comes out on m_axis for it, in order. A new transaction is
// accepted every cycle while the output side keeps up. The pipeline depth is
// set by the divider, which resolves four quotient bits per pipeline stage,
// followed by two alignment stages and the output slice. All opcodes take
// the same path so results stay in order. The 2W-bit product comes from
// four half-width partial products, registered and summed over two stages.
// Division by zero gives an all-ones quotient, the dividend as remainder and
// the div_zero flag. Overflow is never trapped. Backpressure stalls the whole
// pipeline at once, so nothing is lost or repeated.
module mips_integer_alu
    import mia_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[3:0], operand_a[35:4], operand_b[67:36], dest_reg[72:68], zero fill
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // gpr_write[0], write_reg[5:1], gpr_value[37:6], hilo_write[38],
    // lo_value[70:39], hi_value[102:71], div_zero[103]
    output logic [103:0] m_axis_tdata
);

    localparam int W      = DATA_WIDTH;
    localparam int HW     = (W + 1) / 2;
    localparam int NDIV   = (W + 3) / 4;
    localparam int DEPTH  = NDIV + 3;

    // Stage 0: decode, operand conditioning. Operands are taken modulo 2^W.
    logic [OPCODE_WIDTH-1:0] op_in;
    logic [W-1:0]            a_in, b_in;
    logic [REG_WIDTH-1:0]    rd_in;
    logic [SHAMT_WIDTH-1:0]  sh_in;

    assign op_in = s_axis_tdata[3:0];
    assign a_in  = W'(s_axis_tdata[4 +: FIELD_WIDTH]);
    assign b_in  = W'(s_axis_tdata[36 +: FIELD_WIDTH]);
    assign rd_in = s_axis_tdata[72:68];
    assign sh_in = s_axis_tdata[40:36];

    // Global stall: the pipeline moves as one when the output slot frees.
    logic adv;
    logic vld_reg [DEPTH];
    assign s_axis_tready = adv;

    // Simple ops finish in stage 0 and ride along.
    logic [W-1:0] gv0;
    logic         gw0, mul0, div0, sgn0, na0, nb0, dz0, ovf0;
    logic [W-1:0] ma0, mb0;

    always_comb
    begin
        logic [W-1:0] sra_fill;
        gv0  = '0;
        gw0  = 1'b1;
        mul0 = 1'b0;
        div0 = 1'b0;
        sgn0 = 1'b0;
        sra_fill = {W{a_in[W-1]}};
        case (opcode_t'(op_in))
            OP_ADD:   gv0 = a_in + b_in;
            OP_SUB:   gv0 = a_in - b_in;
            OP_AND:   gv0 = a_in & b_in;
            OP_OR:    gv0 = a_in | b_in;
            OP_XOR:   gv0 = a_in ^ b_in;
            OP_NOR:   gv0 = ~(a_in | b_in);
            OP_SLL:   gv0 = (32'(sh_in) < W) ? (a_in << sh_in) : '0;
            OP_SRL:   gv0 = (32'(sh_in) < W) ? (a_in >> sh_in) : '0;
            OP_SRA:   gv0 = (32'(sh_in) < W)
                          ? ((a_in >> sh_in) | ~(sra_fill >> sh_in) & sra_fill
                             | (a_in >> sh_in))
                          : sra_fill;
            OP_SLT:   gv0 = W'($signed(a_in) < $signed(b_in));
            OP_SLTU:  gv0 = W'(a_in < b_in);
            OP_MULT:  begin gw0 = 1'b0; mul0 = 1'b1; sgn0 = 1'b1; end
            OP_MULTU: begin gw0 = 1'b0; mul0 = 1'b1; end
            OP_DIV:   begin gw0 = 1'b0; div0 = 1'b1; sgn0 = 1'b1; end
            OP_DIVU:  begin gw0 = 1'b0; div0 = 1'b1; end
            default:  gw0 = 1'b0;
        endcase
        na0  = sgn0 && a_in[W-1];
        nb0  = sgn0 && b_in[W-1];
        ma0  = na0 ? (W'(0) - a_in) : a_in;
        mb0  = nb0 ? (W'(0) - b_in) : b_in;
        dz0  = div0 && (b_in == '0);
        ovf0 = div0 && sgn0 && (a_in == {1'b1, {(W-1){1'b0}}}) && (b_in == '1);
    end

    // Side data carried through the whole pipeline.
    typedef struct packed {
        ctl_t         ctl;
        logic [W-1:0] gv;
        logic [W-1:0] a;
        logic         na;
        logic         nb;
        logic         dz;
        logic         ovf;
    } side_t;

    side_t side_reg [DEPTH];
    side_t side0;

    always_comb
    begin
        side0.ctl.is_mul    = mul0;
        side0.ctl.is_div    = div0;
        side0.ctl.gpr_write = gw0;
        side0.ctl.write_reg = rd_in;
        side0.gv            = gv0;
        side0.a             = a_in;
        side0.na            = na0;
        side0.nb            = nb0;
        side0.dz            = dz0;
        side0.ovf           = ovf0;
    end

    always_comb
    begin
        vld_reg[0]  = s_axis_tvalid;
        side_reg[0] = side0;
    end

    for (genvar i = 0; i < DEPTH - 1; i++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // Multiplier on magnitudes: partial products, then sum, then sign fix.
    logic [HW-1:0]    pa_lo, pa_hi, pb_lo, pb_hi;
    logic [2*HW-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [4*HW-1:0]  prod_reg;
    logic [2*W-1:0]   prod_delay_reg [DEPTH-3];

    assign pa_lo = ma0[HW-1:0];
    assign pb_lo = mb0[HW-1:0];
    assign pa_hi = HW'({{(2*HW-W){1'b0}}, ma0} >> HW);
    assign pb_hi = HW'({{(2*HW-W){1'b0}}, mb0} >> HW);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg  <= pa_lo * pb_lo;
            p01_reg  <= pa_lo * pb_hi;
            p10_reg  <= pa_hi * pb_lo;
            p11_reg  <= pa_hi * pb_hi;
            prod_reg <= {(2*HW)'(0), p00_reg} + ({(2*HW)'(0), p01_reg} << HW)
                      + ({(2*HW)'(0), p10_reg} << HW) + ({p11_reg, (2*HW)'(0)});
        end
    end

    for (genvar i = 0; i < DEPTH - 3; i++)
    begin : g_pdly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (i == 0)
                begin
                    prod_delay_reg[i] <= prod_reg[2*W-1:0];
                end
                else
                begin
                    prod_delay_reg[i] <= prod_delay_reg[i-1];
                end
            end
        end
    end

    // Divider on magnitudes.
    logic [W-1:0] quo, rem;

    mia_divider #(
        .DATA_WIDTH     (W),
        .BITS_PER_STAGE (4)
    ) u_div (
        .clk       (clk),
        .adv       (adv),
        .dividend  (ma0),
        .divisor   (mb0),
        .quotient  (quo),
        .remainder (rem)
    );

    // Stage NDIV: results of the divider align with side_reg[NDIV].
    logic [W-1:0] quo_reg, rem_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_reg <= quo;
            rem_reg <= rem;
        end
    end

    // Last stages: sign fix and output formatting, then output slice.
    side_t        sf;
    logic [2*W-1:0] pm;
    logic [W-1:0] lo_n, hi_n;
    logic [103:0] out_next;

    assign sf = side_reg[DEPTH-1];

    // The registered divider result is one stage later than the divider's last
    // stage; delay it once more to line up with side_reg[DEPTH-1].
    logic [W-1:0] quo_d_reg, rem_d_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_d_reg <= quo_reg;
            rem_d_reg <= rem_reg;
        end
    end

    assign pm = prod_delay_reg[DEPTH-4];

    always_comb
    begin
        logic [2*W-1:0] p;
        lo_n = '0;
        hi_n = '0;
        p    = (sf.na ^ sf.nb) ? ((2*W)'(0) - pm) : pm;
        if (sf.ctl.is_mul)
        begin
            lo_n = p[W-1:0];
            hi_n = p[2*W-1:W];
        end
        else if (sf.ctl.is_div)
        begin
            if (sf.dz)
            begin
                lo_n = '1;
                hi_n = sf.a;
            end
            else if (sf.ovf)
            begin
                lo_n = sf.a;
                hi_n = '0;
            end
            else
            begin
                lo_n = (sf.na ^ sf.nb) ? (W'(0) - quo_d_reg) : quo_d_reg;
                hi_n = sf.na ? (W'(0) - rem_d_reg) : rem_d_reg;
            end
        end
        out_next = '0;
        out_next[0]      = sf.ctl.gpr_write;
        out_next[5:1]    = sf.ctl.write_reg;
        out_next[6 +: FIELD_WIDTH]  = sf.ctl.gpr_write ? FIELD_WIDTH'(sf.gv) : '0;
        out_next[38]     = sf.ctl.is_mul || sf.ctl.is_div;
        out_next[39 +: FIELD_WIDTH] = FIELD_WIDTH'(lo_n);
        out_next[71 +: FIELD_WIDTH] = FIELD_WIDTH'(hi_n);
        out_next[103]    = sf.dz;
    end

    // Output slice; its ready decides whether the whole pipeline advances.
    mia_pipe_stage #(
        .WIDTH (104)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[DEPTH-1]),
        .in_ready  (adv),
        .in_data   (out_next),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[38]))
        else $error("gpr and hilo written together");
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[103] |-> m_axis_tdata[38])
        else $error("div_zero without hilo write");

endmodule

// ===== rtl/mia_pipe_stage.sv =====
// One register slice of the pipeline with a valid bit. The stage takes a new
// transaction whenever it is empty or its content moves on in the same cycle.
module mia_pipe_stage
    import mia_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/mia_divider.sv =====
// Unsigned restoring divider unrolled into stages of BITS_PER_STAGE quotient
// bits each. Items advance in lockstep with the rest of the pipeline on adv.
module mia_divider
    import mia_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int BITS_PER_STAGE = 4
)
(
    input  logic                  clk,
    input  logic                  adv,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int NSTAGE = (DATA_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    logic [DATA_WIDTH-1:0] rem_reg [NSTAGE+1];
    logic [DATA_WIDTH-1:0] quo_reg [NSTAGE+1];
    logic [DATA_WIDTH-1:0] dvs_reg [NSTAGE+1];

    always_comb
    begin
        rem_reg[0] = '0;
        quo_reg[0] = dividend;
        dvs_reg[0] = divisor;
    end

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        logic [DATA_WIDTH-1:0] rem_next;
        logic [DATA_WIDTH-1:0] quo_next;

        always_comb
        begin
            logic [DATA_WIDTH:0] trial;
            trial    = '0;
            rem_next = rem_reg[s];
            quo_next = quo_reg[s];
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                if (s * BITS_PER_STAGE + k < DATA_WIDTH)
                begin
                    trial = {rem_next, quo_next[DATA_WIDTH-1]}
                          - {1'b0, dvs_reg[s]};
                    quo_next = {quo_next[DATA_WIDTH-2:0], !trial[DATA_WIDTH]};
                    if (!trial[DATA_WIDTH])
                    begin
                        rem_next = trial[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        rem_next = {rem_next[DATA_WIDTH-2:0],
                                    quo_reg[s][DATA_WIDTH-1-k]};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= rem_next;
                quo_reg[s+1] <= quo_next;
                dvs_reg[s+1] <= dvs_reg[s];
            end
        end
    end

    assign quotient  = quo_reg[NSTAGE];
    assign remainder = rem_reg[NSTAGE];

endmodule

// ===== tb/tb_mips_integer_alu.sv =====
`timescale 1ns / 100ps

// Testbench for the MIPS32 integer execute unit. Instructions go in on the
// s_axis side and one register-file write comes back per instruction on the
// m_axis side, in order. Each accepted instruction is run through a local
// model of the execute unit and the expected write is queued. Every output
// transaction is compared field by field against the oldest queued write.
module tb_mips_integer_alu;

    import mia_pkg::*;

    // One register-file write as the unit reports it.
    typedef struct packed {
        logic        div_zero;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        hilo_write;
        logic [31:0] gpr_value;
        logic [4:0]  write_reg;
        logic        gpr_write;
    } alu_write_t;

    // One row of the directed table. When has_exp is set, the write is typed
    // in by hand and checked against the model as well.
    typedef struct {
        opcode_t     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  rd;
        bit          has_exp;
        alu_write_t  exp;
    } insn_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    alu_write_t pending_writes[$];
    int         error_count;
    bit         hold_receiver;

    mips_integer_alu dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Computes the register-file write that one instruction causes.
    function automatic alu_write_t execute_insn(logic [3:0] op, logic [31:0] a,
                                                logic [31:0] b, logic [4:0] rd);
        alu_write_t        w;
        logic [4:0]        shamt;
        logic signed [63:0] sprod;
        logic [63:0]       uprod;
        logic [31:0]       mag_a;
        logic [31:0]       mag_b;
        logic [31:0]       quo;
        logic [31:0]       rem;
        w = '0;
        w.write_reg = rd;
        shamt = b[4:0];
        if (op <= OP_SLTU)
        begin
            w.gpr_write = 1'b1;
            case (op)
                OP_ADD:  w.gpr_value = a + b;
                OP_SUB:  w.gpr_value = a - b;
                OP_AND:  w.gpr_value = a & b;
                OP_OR:   w.gpr_value = a | b;
                OP_XOR:  w.gpr_value = a ^ b;
                OP_NOR:  w.gpr_value = ~(a | b);
                OP_SLL:  w.gpr_value = a << shamt;
                OP_SRL:  w.gpr_value = a >> shamt;
                OP_SRA:  w.gpr_value = $signed(a) >>> shamt;
                OP_SLT:  w.gpr_value = {31'd0, $signed(a) < $signed(b)};
                default: w.gpr_value = {31'd0, a < b};
            endcase
        end
        else if (op <= OP_DIVU)
        begin
            w.hilo_write = 1'b1;
            if (op == OP_MULT)
            begin
                sprod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {w.hi_value, w.lo_value} = sprod;
            end
            else if (op == OP_MULTU)
            begin
                uprod = {32'd0, a} * {32'd0, b};
                {w.hi_value, w.lo_value} = uprod;
            end
            else if (b == 32'd0)
            begin
                // A zero divisor gives an all-ones quotient and keeps the dividend.
                w.lo_value = '1;
                w.hi_value = a;
                w.div_zero = 1'b1;
            end
            else if (op == OP_DIVU)
            begin
                w.lo_value = a / b;
                w.hi_value = a % b;
            end
            else
            begin
                // Divide magnitudes, then restore signs: quotient toward zero,
                // remainder follows the dividend. The minimum over minus one
                // wraps back to the minimum on its own here.
                mag_a = a[31] ? -a : a;
                mag_b = b[31] ? -b : b;
                quo = mag_a / mag_b;
                rem = mag_a % mag_b;
                w.lo_value = (a[31] != b[31]) ? -quo : quo;
                w.hi_value = a[31] ? -rem : rem;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Draws an operand biased toward the edges of the 32-bit range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Random idle length: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // Holds one instruction on the bus until it is accepted, after a random gap
    // if idle_ok is set, and queues its expected write. Valid stays up on return
    // so the next instruction can follow at once; the caller drops it at the end.
    task automatic send_insn(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                             logic [4:0] rd, bit idle_ok);
        int gap;
        gap = idle_ok ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rd, b, a, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_writes.push_back(execute_insn(op, a, b, rd));
    endtask

    // Receiver: random stalls, with long runs of always-ready; it stalls on every pass while hold_receiver is set.
    initial
    begin : receiver
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver || $urandom_range(0, 3) == 0)
            begin
                stall = hold_receiver ? 20 : pick_gap();
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Checks each output transaction against the oldest expected write.
    always @(posedge clk)
    begin
        alu_write_t got;
        alu_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_writes.size() == 0)
            begin
                $display("[%0t] output transaction with no instruction pending", $time);
                error_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got.gpr_write != want.gpr_write)
                    report_mismatch("gpr_write", 32'(got.gpr_write), 32'(want.gpr_write));
                if (got.write_reg != want.write_reg)
                    report_mismatch("write_reg", 32'(got.write_reg), 32'(want.write_reg));
                if (got.gpr_value != want.gpr_value)
                    report_mismatch("gpr_value", got.gpr_value, want.gpr_value);
                if (got.hilo_write != want.hilo_write)
                    report_mismatch("hilo_write", 32'(got.hilo_write),
                                    32'(want.hilo_write));
                if (got.lo_value != want.lo_value)
                    report_mismatch("lo_value", got.lo_value, want.lo_value);
                if (got.hi_value != want.hi_value)
                    report_mismatch("hi_value", got.hi_value, want.hi_value);
                if (got.div_zero != want.div_zero)
                    report_mismatch("div_zero", 32'(got.div_zero), 32'(want.div_zero));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run of about 1700 instructions.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        insn_row_t   rows[$];
        alu_write_t  e;
        alu_write_t  model;
        int          drain;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        hold_receiver = 1'b0;

        // Directed table. Hand-typed results cover zero-divisor, signed
        // overflow in divide, the unused opcode and the obvious extremes.
        e = '0; e.write_reg = 5'd31; e.gpr_write = 1'b1; e.gpr_value = 32'h0;
        rows.push_back('{OP_ADD, 32'hFFFF_FFFF, 32'h1, 5'd31, 1, e});
        e = '0; e.gpr_write = 1'b1; e.gpr_value = 32'hFFFF_FFFF;
        rows.push_back('{OP_SUB, 32'h0, 32'h1, 5'd0, 1, e});
        e = '0; e.write_reg = 5'd7; e.gpr_write = 1'b1; e.gpr_value = 32'h0000_0000;
        rows.push_back('{OP_NOR, 32'hFFFF_0000, 32'h0000_FFFF, 5'd7, 1, e});
        e = '0; e.write_reg = 5'd1; e.gpr_write = 1'b1; e.gpr_value = 32'h8000_0000;
        rows.push_back('{OP_SLL, 32'h1, 32'hFFFF_FFFF, 5'd1, 1, e});
        e = '0; e.write_reg = 5'd2; e.gpr_write = 1'b1; e.gpr_value = 32'hFFFF_FFFF;
        rows.push_back('{OP_SRA, 32'h8000_0000, 32'h1F, 5'd2, 1, e});
        e = '0; e.write_reg = 5'd3; e.gpr_write = 1'b1; e.gpr_value = 32'h1;
        rows.push_back('{OP_SRL, 32'h8000_0000, 32'h1F, 5'd3, 1, e});
        e = '0; e.write_reg = 5'd4; e.gpr_write = 1'b1; e.gpr_value = 32'h1;
        rows.push_back('{OP_SLT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd4, 1, e});
        e = '0; e.write_reg = 5'd5; e.gpr_write = 1'b1; e.gpr_value = 32'h0;
        rows.push_back('{OP_SLTU, 32'h8000_0000, 32'h7FFF_FFFF, 5'd5, 1, e});
        e = '0; e.write_reg = 5'd9; e.hilo_write = 1'b1;
        e.lo_value = 32'h1; e.hi_value = 32'hFFFF_FFFE;
        rows.push_back('{OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd9, 1, e});
        e = '0; e.write_reg = 5'd10; e.hilo_write = 1'b1;
        e.lo_value = 32'h1; e.hi_value = 32'h0;
        rows.push_back('{OP_MULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd10, 1, e});
        e = '0; e.write_reg = 5'd11; e.hilo_write = 1'b1; e.div_zero = 1'b1;
        e.lo_value = 32'hFFFF_FFFF; e.hi_value = 32'h1234_5678;
        rows.push_back('{OP_DIV, 32'h1234_5678, 32'h0, 5'd11, 1, e});
        e = '0; e.write_reg = 5'd12; e.hilo_write = 1'b1; e.div_zero = 1'b1;
        e.lo_value = 32'hFFFF_FFFF; e.hi_value = 32'hFFFF_FFFF;
        rows.push_back('{OP_DIVU, 32'hFFFF_FFFF, 32'h0, 5'd12, 1, e});
        e = '0; e.write_reg = 5'd13; e.hilo_write = 1'b1;
        e.lo_value = 32'h8000_0000; e.hi_value = 32'h0;
        rows.push_back('{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 5'd13, 1, e});
        e = '0; e.write_reg = 5'd31;
        rows.push_back('{OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1, e});
        // Rows left to the model alone.
        rows.push_back('{OP_AND, 32'hDEAD_BEEF, 32'h0F0F_F0F0, 5'd14, 0, '0});
        rows.push_back('{OP_OR, 32'h1234_0000, 32'h0000_5678, 5'd15, 0, '0});
        rows.push_back('{OP_XOR, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 5'd16, 0, '0});
        rows.push_back('{OP_SRA, 32'h7654_3210, 32'hFFFF_FFE4, 5'd17, 0, '0});
        rows.push_back('{OP_MULT, 32'h8000_0000, 32'h8000_0000, 5'd18, 0, '0});
        rows.push_back('{OP_MULT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd19, 0, '0});
        rows.push_back('{OP_DIV, 32'hFFFF_FFF9, 32'h2, 5'd20, 0, '0});
        rows.push_back('{OP_DIV, 32'h7, 32'hFFFF_FFFE, 5'd21, 0, '0});
        rows.push_back('{OP_DIVU, 32'hFFFF_FFFF, 32'h7, 5'd22, 0, '0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].has_exp)
            begin
                model = execute_insn(rows[i].op, rows[i].a, rows[i].b, rows[i].rd);
                if (model != rows[i].exp)
                begin
                    $display("directed row %0d: typed result disagrees with model", i);
                    error_count++;
                end
            end
            send_insn(rows[i].op, rows[i].a, rows[i].b, rows[i].rd, 1'b1);
        end
        s_axis_tvalid <= 1'b0;

        // Random part. Every opcode including the unused one; the sender
        // pauses a few times until every expected write has come back, once
        // with the receiver held off so the pipeline fills under backpressure.
        for (int n = 0; n < 1700; n++)
        begin
            if (n % 500 == 250)
            begin
                hold_receiver = (n == 250);
                if (hold_receiver)
                begin
                    for (int k = 0; k < 20; k++)
                        send_insn(4'($urandom_range(0, 15)), pick_operand(),
                                  pick_operand(), 5'($urandom_range(0, 31)), 1'b0);
                    hold_receiver = 1'b0;
                end
                s_axis_tvalid <= 1'b0;
                while (pending_writes.size() != 0)
                    @(posedge clk);
            end
            send_insn(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                      5'($urandom_range(0, 31)), 1'b1);
        end
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (pending_writes.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_writes.size() != 0)
        begin
            $display("%0d expected writes never arrived", pending_writes.size());
            error_count++;
        end
        // Let any stray output show up after the last expected one.
        repeat (30) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
